// File: rtl/abms_pkg.sv
// ----------------------------------------------------------------------------
// abms_pkg
// Shared types and constants for the alpha-beta minimax search core.
// ----------------------------------------------------------------------------
`default_nettype none

package abms_pkg;

    localparam int SCORE_W = 32;

    typedef logic signed [SCORE_W-1:0] t_score;

    localparam t_score INT_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
    localparam t_score INT_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

    // Status of the search engine as seen by the load and output logic.
    typedef struct packed {
        logic busy;
        logic done;
    } t_srch_stat;

endpackage

`default_nettype wire

// File: rtl/abms_ram.sv
// ----------------------------------------------------------------------------
// abms_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module abms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/abms_search.sv
// ----------------------------------------------------------------------------
// abms_search
// Depth-first alpha-beta sequencer. The active frame sits in registers and
// the frames of its ancestors are kept in a stack RAM indexed by level.
// ----------------------------------------------------------------------------
`default_nettype none

module abms_search
    import abms_pkg::*;
#(
    parameter int MAX_DEPTH = 10,
    parameter int AW        = MAX_DEPTH,
    parameter int DW        = $clog2(MAX_DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_depth,
    output logic      [AW-1:0] o_leaf_raddr,
    input  wire t_score        i_leaf_rdata,
    output t_srch_stat         o_stat,
    output t_score             o_result
);

    localparam int SW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW = DW + 1;

    typedef struct packed {
        logic   stage;
        t_score alpha;
        t_score beta;
    } t_frame;

    localparam int FRAME_W = $bits(t_frame);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXPAND,
        S_LEAF,
        S_APPLY,
        S_POP
    } t_state;

    t_state          r_state, n_state;
    logic [SW-1:0]   r_sp, n_sp;
    logic [AW-1:0]   r_pos, n_pos;
    logic            r_stage, n_stage;
    t_score          r_alpha, n_alpha;
    t_score          r_beta, n_beta;
    t_score          r_v, n_v;

    t_score          w_na, w_nb, w_ret;
    logic            w_done;
    logic            w_descend;
    logic            w_stk_we;
    t_frame          w_stk_wdata;
    logic [FRAME_W-1:0] w_stk_rdata;
    t_frame          w_stk_frame;

    abms_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (MAX_DEPTH),
        .AW    (SW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (r_sp),
        .i_wdata (w_stk_wdata),
        .i_raddr (SW'(r_sp - SW'(1))),
        .o_rdata (w_stk_rdata)
    );

    assign w_stk_frame  = t_frame'(w_stk_rdata);
    assign w_stk_wdata  = '{stage: r_stage, alpha: r_alpha, beta: r_beta};
    assign o_leaf_raddr = AW'({r_pos, r_stage});
    assign w_descend    = (CW'(r_sp) + CW'(1)) < CW'(i_depth);
    assign w_stk_we     = (r_state == S_EXPAND) && w_descend;

    // Odd levels minimize and even levels maximize.
    always_comb begin
        w_na = r_alpha;
        w_nb = r_beta;
        if (r_sp[0]) begin
            if (r_v < r_beta) begin
                w_nb = r_v;
            end
            w_ret = w_nb;
        end else begin
            if (r_v > r_alpha) begin
                w_na = r_v;
            end
            w_ret = w_na;
        end
        w_done = (w_na >= w_nb) || r_stage;
    end

    always_comb begin
        n_state = r_state;
        n_sp    = r_sp;
        n_pos   = r_pos;
        n_stage = r_stage;
        n_alpha = r_alpha;
        n_beta  = r_beta;
        n_v     = r_v;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_alpha = INT_MIN;
                    n_beta  = INT_MAX;
                    n_sp    = '0;
                    n_pos   = '0;
                    n_stage = 1'b0;
                    n_state = S_EXPAND;
                end
            end
            S_EXPAND: begin
                if (w_descend) begin
                    n_pos   = AW'({r_pos, r_stage});
                    n_stage = 1'b0;
                    n_sp    = SW'(r_sp + SW'(1));
                end else begin
                    n_state = S_LEAF;
                end
            end
            S_LEAF: begin
                n_v     = i_leaf_rdata;
                n_state = S_APPLY;
            end
            S_APPLY: begin
                n_alpha = w_na;
                n_beta  = w_nb;
                if (!w_done) begin
                    n_stage = 1'b1;
                    n_state = S_EXPAND;
                end else if (r_sp == '0) begin
                    n_state = S_IDLE;
                end else begin
                    // Hand the bound up to the parent frame fetched from the stack.
                    n_v     = w_ret;
                    n_sp    = SW'(r_sp - SW'(1));
                    n_pos   = r_pos >> 1;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                n_alpha = w_stk_frame.alpha;
                n_beta  = w_stk_frame.beta;
                n_stage = w_stk_frame.stage;
                n_state = S_APPLY;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_sp    <= n_sp;
        r_pos   <= n_pos;
        r_stage <= n_stage;
        r_alpha <= n_alpha;
        r_beta  <= n_beta;
        r_v     <= n_v;
    end

    assign o_stat   = '{busy: (r_state != S_IDLE),
                        done: ((r_state == S_APPLY) && w_done && (r_sp == '0))};
    assign o_result = w_ret;

endmodule

`default_nettype wire

// File: rtl/alpha_beta_minimax_search_core.sv
// ----------------------------------------------------------------------------
// alpha_beta_minimax_search_core
// Leaves load at one transaction per cycle into the leaf RAM; input stalls
// while the search runs or the last leaf waits on a held result. The last
// leaf starts the search: descents in S_EXPAND, leaf visits via S_EXPAND,
// S_LEAF, S_APPLY, returns via S_POP, S_APPLY. Depth zero passes each leaf
// straight to the output. Synchronous reset: depth 4, load count zero, idle.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_beta_minimax_search_core
    import abms_pkg::*;
#(
    parameter int MAX_DEPTH = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_score      i_leaf_value,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_score           o_root_value
);

    localparam int AW = MAX_DEPTH;
    localparam int DW = $clog2(MAX_DEPTH + 1);

    logic [3:0]    r_depth_cfg;
    logic [AW:0]   r_load_cnt;
    logic          r_out_valid;
    t_score        r_root;

    logic [DW-1:0] w_depth;
    logic [AW:0]   w_leaves;
    logic          w_last;
    logic          w_in_acc;
    logic          w_out_hold;
    t_srch_stat    w_stat;
    t_score        w_result;
    logic [AW-1:0] w_leaf_raddr;
    t_score        w_leaf_rdata;

    assign w_depth    = ({1'b0, r_depth_cfg} > 5'(MAX_DEPTH)) ? DW'(MAX_DEPTH)
                                                              : DW'(r_depth_cfg);
    assign w_leaves   = (AW+1)'(1) << w_depth;
    assign w_last     = (r_load_cnt + (AW+1)'(1)) == w_leaves;
    assign w_out_hold = r_out_valid && i_out_stall;
    assign o_in_stall = w_stat.busy || (w_last && w_out_hold);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    abms_ram #(
        .WIDTH (SCORE_W),
        .DEPTH (2 ** MAX_DEPTH),
        .AW    (AW)
    ) u_leaf_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc),
        .i_waddr (r_load_cnt[AW-1:0]),
        .i_wdata (i_leaf_value),
        .i_raddr (w_leaf_raddr),
        .o_rdata (w_leaf_rdata)
    );

    abms_search #(
        .MAX_DEPTH (MAX_DEPTH),
        .AW        (AW),
        .DW        (DW)
    ) u_search (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_in_acc && w_last && (w_depth != '0)),
        .i_depth      (w_depth),
        .o_leaf_raddr (w_leaf_raddr),
        .i_leaf_rdata (w_leaf_rdata),
        .o_stat       (w_stat),
        .o_result     (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_cfg <= 4'd4;
            r_load_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_depth_cfg <= i_cfg_wdata;
                r_load_cnt  <= '0;
            end else if (w_in_acc) begin
                r_load_cnt <= w_last ? '0 : r_load_cnt + (AW+1)'(1);
            end

            // The search result is the root value; a single-leaf tree is its own root value.
            if (w_stat.done) begin
                r_out_valid <= 1'b1;
                r_root      <= w_result;
            end else if (w_in_acc && w_last && (w_depth == '0)) begin
                r_out_valid <= 1'b1;
                r_root      <= i_leaf_value;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_root_value = r_root;

    a_no_load_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy |-> o_in_stall)
        else $error("input transaction accepted while search runs");

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (w_stat.busy && !r_out_valid))
        else $error("search result arrives with output register occupied");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load_cnt < w_leaves)
        else $error("leaf load count beyond tree size");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_root)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire
